// File: rtl/bcc_pkg.sv
// Shared constants, event codes and inter-module structs for the button
// click classifier. No dependencies.
`default_nettype none
package bcc_pkg;

  localparam int NUM_KEYS_DEF = 4;
  localparam int MAX_RESULTS  = 8;
  localparam int PIN_W        = 4;
  localparam int KEY_W        = 2;
  localparam int CODE_W       = 3;
  localparam int MS_W         = 32;
  localparam int TICK_W       = 16;
  localparam int PERIOD_W     = 8;
  localparam int ADDR_W       = 5;
  localparam int DATA_W       = 32;

  localparam logic [CODE_W-1:0] EV_NONE   = 3'd0;
  localparam logic [CODE_W-1:0] EV_DOWN   = 3'd1;
  localparam logic [CODE_W-1:0] EV_UP     = 3'd2;
  localparam logic [CODE_W-1:0] EV_SINGLE = 3'd3;
  localparam logic [CODE_W-1:0] EV_DOUBLE = 3'd4;
  localparam logic [CODE_W-1:0] EV_LONG   = 3'd5;
  localparam logic [CODE_W-1:0] EV_REPEAT = 3'd6;

  localparam logic [2:0] REG_POLARITY = 3'd0;
  localparam logic [2:0] REG_PERIOD   = 3'd1;
  localparam logic [2:0] REG_LONG     = 3'd2;
  localparam logic [2:0] REG_GAP      = 3'd3;
  localparam logic [2:0] REG_REPEAT   = 3'd4;

  localparam logic [PIN_W-1:0]    POLARITY_RST = 4'd0;
  localparam logic [PERIOD_W-1:0] PERIOD_RST   = 8'd20;
  localparam logic [TICK_W-1:0]   LONG_RST     = 16'd1000;
  localparam logic [TICK_W-1:0]   GAP_RST      = 16'd200;
  localparam logic [TICK_W-1:0]   REPEAT_RST   = 16'd100;

  typedef struct packed {
    logic [TICK_W-1:0] long_ticks;
    logic [TICK_W-1:0] gap_ticks;
    logic [TICK_W-1:0] repeat_ticks;
  } lane_cfg_t;

  typedef struct packed {
    logic [CODE_W-1:0] edge_code;
    logic [CODE_W-1:0] fsm_code;
    logic              level;
    logic [MS_W-1:0]   held;
  } lane_res_t;

endpackage
`default_nettype wire

// File: rtl/bcc_if.sv
// Valid/ready channel interfaces for tick requests and event results.
// Depends on bcc_pkg.
`default_nettype none
interface bcc_in_if;
  logic                        valid;
  logic                        ready;
  logic [bcc_pkg::PIN_W-1:0]   pin_levels;
  modport source (output valid, output pin_levels, input ready);
  modport sink   (input valid, input pin_levels, output ready);
endinterface

interface bcc_out_if;
  logic                         valid;
  logic                         ready;
  logic [bcc_pkg::KEY_W-1:0]    key_index;
  logic [bcc_pkg::CODE_W-1:0]   event_code;
  logic [bcc_pkg::MS_W-1:0]     held_ms;
  logic [bcc_pkg::PIN_W-1:0]    hold_mask;
  logic                         last;
  modport source (output valid, output key_index, output event_code, output held_ms,
                  output hold_mask, output last, input ready);
  modport sink   (input valid, input key_index, input event_code, input held_ms,
                  input hold_mask, input last, output ready);
endinterface
`default_nettype wire

// File: rtl/button_click_classifier.sv
// Button click classifier: one request per millisecond tick carries the raw
// pin levels of the keys. When a tick request is taken, the millisecond
// counter and sample divider advance, and NUM_KEYS parallel lanes update
// their countdowns and, on a sample tick, their edge detectors and click
// state machines. The merge stage then hands out the tick's events in key
// order (edge event before state event per key), one result per cycle while
// the result channel is not stalled, at most eight per tick; a tick with no
// event yields one "none" result that carries the hold mask. Results pass
// through the merge stage's single output register. Input ready rises in the
// cycle after the last result of the previous tick has moved into that
// register. No clearing pass after reset.
// Depends on bcc_pkg, bcc_if, bcc_lane, bcc_merge.
`default_nettype none
module button_click_classifier #(
  parameter int NUM_KEYS = bcc_pkg::NUM_KEYS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  bcc_in_if.sink                             in_ch,
  bcc_out_if.source                          out_ch,
  // APB-style register port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [bcc_pkg::ADDR_W-1:0]    paddr,
  input  wire logic [bcc_pkg::DATA_W-1:0]    pwdata,
  output logic [bcc_pkg::DATA_W-1:0]         prdata,
  output logic                               pready
);

  // configuration registers
  logic [bcc_pkg::PIN_W-1:0]     pol_r;
  logic [bcc_pkg::PERIOD_W-1:0]  period_r;
  logic [bcc_pkg::TICK_W-1:0]    long_r, gap_r, rpt_r;
  logic [2:0]                    reg_idx;
  logic                          wr_en;

  // tick timing
  logic [bcc_pkg::MS_W-1:0]      ms_r, ms_nxt;
  logic [bcc_pkg::PERIOD_W-1:0]  div_r, div_nxt, div_inc;
  logic                          sample, tick, pending;

  bcc_pkg::lane_cfg_t            lane_cfg;
  bcc_pkg::lane_res_t            lane_res [NUM_KEYS];
  logic [bcc_pkg::PIN_W-1:0]     hold_mask;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pol_r    <= bcc_pkg::POLARITY_RST;
      period_r <= bcc_pkg::PERIOD_RST;
      long_r   <= bcc_pkg::LONG_RST;
      gap_r    <= bcc_pkg::GAP_RST;
      rpt_r    <= bcc_pkg::REPEAT_RST;
    end else if (wr_en) begin
      case (reg_idx)
        bcc_pkg::REG_POLARITY: pol_r    <= pwdata[bcc_pkg::PIN_W-1:0];
        bcc_pkg::REG_PERIOD:   period_r <= pwdata[bcc_pkg::PERIOD_W-1:0];
        bcc_pkg::REG_LONG:     long_r   <= pwdata[bcc_pkg::TICK_W-1:0];
        bcc_pkg::REG_GAP:      gap_r    <= pwdata[bcc_pkg::TICK_W-1:0];
        bcc_pkg::REG_REPEAT:   rpt_r    <= pwdata[bcc_pkg::TICK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      bcc_pkg::REG_POLARITY: prdata = bcc_pkg::DATA_W'(pol_r);
      bcc_pkg::REG_PERIOD:   prdata = bcc_pkg::DATA_W'(period_r);
      bcc_pkg::REG_LONG:     prdata = bcc_pkg::DATA_W'(long_r);
      bcc_pkg::REG_GAP:      prdata = bcc_pkg::DATA_W'(gap_r);
      bcc_pkg::REG_REPEAT:   prdata = bcc_pkg::DATA_W'(rpt_r);
      default:               prdata = '0;
    endcase
  end

  // a new tick request only when the previous tick's events are all handed on
  assign in_ch.ready = !pending;
  assign tick        = in_ch.valid && in_ch.ready;

  // divider test is >= so a lowered period (or zero) samples on the next tick
  always_comb begin
    ms_nxt  = ms_r + 1'b1;
    div_inc = div_r + 1'b1;
    sample  = (div_inc >= period_r);
    div_nxt = sample ? '0 : div_inc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ms_r  <= '0;
      div_r <= '0;
    end else if (tick) begin
      ms_r  <= ms_nxt;
      div_r <= div_nxt;
    end
  end

  assign lane_cfg.long_ticks   = long_r;
  assign lane_cfg.gap_ticks    = gap_r;
  assign lane_cfg.repeat_ticks = rpt_r;

  // keys past the pin field read level 0 and are active low
  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
    logic pin_k, pol_k;
    if (k < bcc_pkg::PIN_W) begin : g_pin
      assign pin_k = in_ch.pin_levels[k];
      assign pol_k = pol_r[k];
    end else begin : g_nopin
      assign pin_k = 1'b0;
      assign pol_k = 1'b0;
    end
    bcc_lane u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .tick   (tick),
      .sample (sample),
      .pin    (pin_k),
      .pol    (pol_k),
      .ms_now (ms_nxt),
      .cfg    (lane_cfg),
      .res    (lane_res[k])
    );
  end

  // hold mask only covers the keys that have a pin
  for (genvar b = 0; b < bcc_pkg::PIN_W; b++) begin : g_hold
    if (b < NUM_KEYS) begin : g_key
      assign hold_mask[b] = lane_res[b].level;
    end else begin : g_none
      assign hold_mask[b] = 1'b0;
    end
  end

  bcc_merge #(
    .NUM_KEYS (NUM_KEYS)
  ) u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (tick),
    .lane_res  (lane_res),
    .hold_mask (hold_mask),
    .pending   (pending),
    .out_ch    (out_ch)
  );

endmodule
`default_nettype wire

// File: rtl/bcc_lane.sv
// One key lane: level sampling, edge detect, countdown and click state machine.
// Depends on bcc_pkg.
`default_nettype none
module bcc_lane (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         tick,
  input  wire logic                         sample,
  input  wire logic                         pin,
  input  wire logic                         pol,
  input  wire logic [bcc_pkg::MS_W-1:0]     ms_now,
  input  wire bcc_pkg::lane_cfg_t           cfg,
  output bcc_pkg::lane_res_t                res
);

  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_HOLD_UP   = 3'd1;
  localparam logic [2:0] ST_DBL_WAIT  = 3'd2;
  localparam logic [2:0] ST_DBL_UP    = 3'd3;
  localparam logic [2:0] ST_LONG_RPT  = 3'd4;

  logic [2:0]                   st_r, st_nxt;
  logic                         level_r, level_nxt;
  logic [bcc_pkg::TICK_W-1:0]   cd_r, cd_nxt, cd_dec;
  logic [bcc_pkg::MS_W-1:0]     stamp_r, stamp_nxt;
  logic                         pressed;
  logic [bcc_pkg::MS_W-1:0]     held;
  logic [bcc_pkg::CODE_W-1:0]   edge_code, fsm_code;

  always_comb begin
    pressed   = (pin == pol);
    cd_dec    = (cd_r != '0) ? cd_r - 1'b1 : cd_r;
    held      = ms_now - stamp_r;
    edge_code = bcc_pkg::EV_NONE;
    fsm_code  = bcc_pkg::EV_NONE;
    st_nxt    = st_r;
    cd_nxt    = cd_dec;
    stamp_nxt = stamp_r;
    level_nxt = level_r;
    if (sample) begin
      level_nxt = pressed;
      if (pressed && !level_r) begin
        stamp_nxt = ms_now;
        held      = '0;
        edge_code = bcc_pkg::EV_DOWN;
      end else if (!pressed && level_r) begin
        edge_code = bcc_pkg::EV_UP;
      end
      case (st_r)
        ST_IDLE: begin
          if (pressed) begin
            cd_nxt = cfg.long_ticks;
            st_nxt = ST_HOLD_UP;
          end
        end
        ST_HOLD_UP: begin
          if (!pressed) begin
            cd_nxt = cfg.gap_ticks;
            st_nxt = ST_DBL_WAIT;
          end else if (cd_dec == '0) begin
            fsm_code = bcc_pkg::EV_LONG;
            cd_nxt   = cfg.repeat_ticks;
            st_nxt   = ST_LONG_RPT;
          end
        end
        ST_DBL_WAIT: begin
          if (pressed) begin
            fsm_code = bcc_pkg::EV_DOUBLE;
            st_nxt   = ST_DBL_UP;
          end else if (cd_dec == '0) begin
            fsm_code = bcc_pkg::EV_SINGLE;
            st_nxt   = ST_IDLE;
          end
        end
        ST_DBL_UP: begin
          if (!pressed) st_nxt = ST_IDLE;
        end
        ST_LONG_RPT: begin
          if (!pressed) begin
            st_nxt = ST_IDLE;
          end else if (cd_dec == '0) begin
            fsm_code = bcc_pkg::EV_REPEAT;
            cd_nxt   = cfg.repeat_ticks;
          end
        end
        default: st_nxt = ST_IDLE;
      endcase
    end
    res.edge_code = edge_code;
    res.fsm_code  = fsm_code;
    res.level     = level_nxt;
    res.held      = held;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_IDLE;
      level_r <= 1'b0;
      cd_r    <= '0;
      stamp_r <= '0;
    end else if (tick) begin
      st_r    <= st_nxt;
      level_r <= level_nxt;
      cd_r    <= cd_nxt;
      stamp_r <= stamp_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/bcc_merge.sv
// Merge stage: captures all lane events of a tick, then serialises them in key
// order into a registered result stage, capped per tick. Depends on bcc_pkg, bcc_if.
`default_nettype none
module bcc_merge #(
  parameter int NUM_KEYS = bcc_pkg::NUM_KEYS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        load,
  input  wire bcc_pkg::lane_res_t          lane_res [NUM_KEYS],
  input  wire logic [bcc_pkg::PIN_W-1:0]   hold_mask,
  output logic                             pending,
  bcc_out_if.source                        out_ch
);

  localparam int NSLOT = 2 * NUM_KEYS;
  localparam int CW    = $clog2(bcc_pkg::MAX_RESULTS);

  logic [NSLOT-1:0]                 mask_r, mask_nxt, rest;
  logic                             none_r, none_nxt;
  logic [CW-1:0]                    cnt_r, cnt_nxt;
  logic [bcc_pkg::CODE_W-1:0]       edge_r  [NUM_KEYS];
  logic [bcc_pkg::CODE_W-1:0]       fsm_r   [NUM_KEYS];
  logic [bcc_pkg::MS_W-1:0]         held_r  [NUM_KEYS];
  logic [bcc_pkg::PIN_W-1:0]        hmask_r;

  logic                             ov_r, ov_nxt;
  logic [bcc_pkg::KEY_W-1:0]        okey_r;
  logic [bcc_pkg::CODE_W-1:0]       ocode_r;
  logic [bcc_pkg::MS_W-1:0]         oheld_r;
  logic [bcc_pkg::PIN_W-1:0]        omask_r;
  logic                             olast_r;

  logic                             issue, sel_last;
  logic [bcc_pkg::KEY_W-1:0]        sel_key;
  logic [bcc_pkg::CODE_W-1:0]       sel_code;
  logic [bcc_pkg::MS_W-1:0]         sel_held;
  logic [NSLOT-1:0]                 load_mask;

  assign pending = (mask_r != '0) || none_r;
  assign issue   = pending && (!ov_r || out_ch.ready);

  always_comb begin
    for (int k = 0; k < NUM_KEYS; k++) begin
      load_mask[2*k]   = (lane_res[k].edge_code != bcc_pkg::EV_NONE);
      load_mask[2*k+1] = (lane_res[k].fsm_code != bcc_pkg::EV_NONE);
    end
  end

  // lowest pending slot wins: slot 2k is key k's edge event, 2k+1 its state event
  always_comb begin
    sel_key  = '0;
    sel_code = bcc_pkg::EV_NONE;
    sel_held = '0;
    for (int j = NSLOT - 1; j >= 0; j--) begin
      if (mask_r[j]) begin
        sel_key  = bcc_pkg::KEY_W'(j >> 1);
        sel_code = j[0] ? fsm_r[j >> 1] : edge_r[j >> 1];
        sel_held = (sel_code == bcc_pkg::EV_UP || sel_code == bcc_pkg::EV_LONG ||
                    sel_code == bcc_pkg::EV_REPEAT) ? held_r[j >> 1] : '0;
      end
    end
    rest     = mask_r & (mask_r - 1'b1);
    sel_last = none_r || (rest == '0) || (cnt_r == CW'(bcc_pkg::MAX_RESULTS - 1));

    mask_nxt = mask_r;
    none_nxt = none_r;
    cnt_nxt  = cnt_r;
    if (load) begin
      mask_nxt = load_mask;
      none_nxt = (load_mask == '0);
      cnt_nxt  = '0;
    end else if (issue) begin
      if (none_r) none_nxt = 1'b0;
      else        mask_nxt = sel_last ? '0 : rest;
      cnt_nxt = cnt_r + 1'b1;
    end
    ov_nxt = issue ? 1'b1 : (out_ch.ready ? 1'b0 : ov_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
      none_r <= 1'b0;
      cnt_r  <= '0;
      ov_r   <= 1'b0;
    end else begin
      mask_r <= mask_nxt;
      none_r <= none_nxt;
      cnt_r  <= cnt_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        edge_r[k] <= lane_res[k].edge_code;
        fsm_r[k]  <= lane_res[k].fsm_code;
        held_r[k] <= lane_res[k].held;
      end
      hmask_r <= hold_mask;
    end
    if (issue) begin
      okey_r  <= none_r ? '0 : sel_key;
      ocode_r <= none_r ? bcc_pkg::EV_NONE : sel_code;
      oheld_r <= none_r ? '0 : sel_held;
      omask_r <= hmask_r;
      olast_r <= sel_last;
    end
  end

  assign out_ch.valid      = ov_r;
  assign out_ch.key_index  = okey_r;
  assign out_ch.event_code = ocode_r;
  assign out_ch.held_ms    = oheld_r;
  assign out_ch.hold_mask  = omask_r;
  assign out_ch.last       = olast_r;

endmodule
`default_nettype wire

// File: rtl/bcc_checker.sv
// Port-level assertions for the button click classifier, bound to the top level.
// Depends on bcc_pkg, button_click_classifier.
`default_nettype none
module bcc_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [bcc_pkg::KEY_W-1:0]     key_index,
  input wire logic [bcc_pkg::CODE_W-1:0]    event_code,
  input wire logic [bcc_pkg::MS_W-1:0]      held_ms,
  input wire logic [bcc_pkg::PIN_W-1:0]     hold_mask,
  input wire logic                          last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(event_code) && $stable(held_ms)
      && $stable(key_index) && $stable(hold_mask) && $stable(last))
    else $error("result changed while stalled");

  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("tick request taken with events still to deliver");

  a_mid_tick: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !last |-> !in_ready)
    else $error("new tick accepted before tick's results finished");

  a_none_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && event_code == bcc_pkg::EV_NONE |-> last && held_ms == '0 && key_index == '0)
    else $error("malformed none result");

  a_zero_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (event_code == bcc_pkg::EV_DOWN || event_code == bcc_pkg::EV_SINGLE ||
                  event_code == bcc_pkg::EV_DOUBLE) |-> held_ms == '0)
    else $error("held time on an event that carries none");

endmodule

bind button_click_classifier bcc_checker u_bcc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .key_index  (out_ch.key_index),
  .event_code (out_ch.event_code),
  .held_ms    (out_ch.held_ms),
  .hold_mask  (out_ch.hold_mask),
  .last       (out_ch.last)
);
`default_nettype wire
